// ----- design/ffp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared widths, constants and control types of the fractional frame pacer.
// ----------------------------------------------------------------------------
package ffp_pkg;

	localparam int RATE_W  = 24;
	localparam int CATCH_W = 25;
	localparam int TIME_W  = 32;
	localparam int ACC_W   = 40;
	localparam int PROD_W  = 48;
	localparam int SUM_W   = 62;
	localparam int DVD_W   = 46;
	localparam int FRAC_W  = 16;
	localparam int SHR_W   = 12;
	localparam int CNT_W   = 6;
	localparam int IDX_W   = 2;

	localparam int MUL_STEPS = CATCH_W;
	localparam int DIV_STEPS = DVD_W;

	localparam logic [RATE_W-1:0]  DEF_LOGICAL   = 24'd3072;
	localparam logic [RATE_W-1:0]  DEF_HOST      = 24'd15360;
	localparam logic [CATCH_W-1:0] DEF_CATCHUP   = 25'd524288;
	localparam logic [RATE_W-1:0]  COUNT_MAX     = 24'hFFFFFF;

	localparam logic [IDX_W-1:0] REG_LOGICAL = 2'd0;
	localparam logic [IDX_W-1:0] REG_HOST    = 2'd1;
	localparam logic [IDX_W-1:0] REG_CATCHUP = 2'd2;

	typedef struct packed {
		logic load;
		logic mul_init;
		logic mul_step;
		logic accum;
		logic div_step;
		logic commit;
	} ffp_cmd_t;

	typedef struct packed {
		logic tick;
		logic out_free;
	} ffp_sts_t;

endpackage

// ----- design/ffp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_ctrl
// Sequencer: load, rate product, serial multiply, accumulate, serial divide, commit.
// ----------------------------------------------------------------------------
module ffp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ffp_pkg::ffp_sts_t sts,
	output ffp_pkg::ffp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_ADD  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]               state_q;
	logic [2:0]               state_d;
	logic [ffp_pkg::CNT_W-1:0] cnt_q;
	logic [ffp_pkg::CNT_W-1:0] cnt_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				cnt_d = '0;
				if (sts.tick) begin
					state_d = S_ADD;
				end else begin
					cmd.mul_init = 1'b1;
					state_d      = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == ffp_pkg::CNT_W'(ffp_pkg::MUL_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = S_ADD;
				end else begin
					cnt_d = cnt_q + ffp_pkg::CNT_W'(1);
				end
			end
			S_ADD: begin
				cmd.accum = 1'b1;
				cnt_d     = '0;
				state_d   = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == ffp_pkg::CNT_W'(ffp_pkg::DIV_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = S_DONE;
				end else begin
					cnt_d = cnt_q + ffp_pkg::CNT_W'(1);
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ----- design/ffp_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_dp
// Datapath: time clamp, shift-add multiplier, accumulator, restoring divider.
// ----------------------------------------------------------------------------
module ffp_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ffp_pkg::ffp_cmd_t                  cmd,
	input  logic                               action,
	input  logic signed [ffp_pkg::TIME_W-1:0]  elapsed_time,
	input  logic [ffp_pkg::RATE_W-1:0]         lr_eff,
	input  logic [ffp_pkg::RATE_W-1:0]         hr_eff,
	input  logic [ffp_pkg::CATCH_W-1:0]        max_catchup,
	output logic                               tick,
	output logic [ffp_pkg::RATE_W-1:0]         count
);

	logic                          tick_q;
	logic [ffp_pkg::CATCH_W-1:0]   t_q;
	logic [ffp_pkg::PROD_W-1:0]    p_q;
	logic [ffp_pkg::PROD_W-1:0]    mhi_q;
	logic [ffp_pkg::CATCH_W-1:0]   mlo_q;
	logic [ffp_pkg::DVD_W-1:0]     dvd_q;
	logic [ffp_pkg::FRAC_W-1:0]    low_q;
	logic [ffp_pkg::RATE_W-1:0]    rem_q;
	logic [ffp_pkg::ACC_W-1:0]     acc_q;

	logic [ffp_pkg::CATCH_W-1:0]   t_clamp;
	logic [ffp_pkg::PROD_W:0]      mul_sum;
	logic [ffp_pkg::SUM_W-1:0]     addend;
	logic [ffp_pkg::SUM_W-1:0]     sum;
	logic [ffp_pkg::RATE_W:0]      trial;
	logic [ffp_pkg::RATE_W:0]      diff;
	logic                          qbit;

	assign tick = tick_q;

	// negative time adds nothing, long gaps are capped
	always_comb begin
		if (elapsed_time[ffp_pkg::TIME_W-1]) begin
			t_clamp = '0;
		end else if (elapsed_time[ffp_pkg::TIME_W-2:0] >
				{{(ffp_pkg::TIME_W-1-ffp_pkg::CATCH_W){1'b0}}, max_catchup}) begin
			t_clamp = max_catchup;
		end else begin
			t_clamp = elapsed_time[ffp_pkg::CATCH_W-1:0];
		end
	end

	assign mul_sum = {1'b0, mhi_q} + (mlo_q[0] ? {1'b0, p_q} : '0);

	always_comb begin
		if (tick_q) begin
			addend = {{(ffp_pkg::SUM_W-ffp_pkg::ACC_W){1'b0}}, lr_eff,
				{ffp_pkg::FRAC_W{1'b0}}};
		end else begin
			addend = {1'b0, mhi_q, mlo_q[ffp_pkg::CATCH_W-1:ffp_pkg::SHR_W]};
		end
	end

	assign sum   = {{(ffp_pkg::SUM_W-ffp_pkg::ACC_W){1'b0}}, acc_q} + addend;
	assign trial = {rem_q, dvd_q[ffp_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, hr_eff};
	assign qbit  = (trial >= {1'b0, hr_eff});

	assign count = (|dvd_q[ffp_pkg::DVD_W-1:ffp_pkg::RATE_W]) ? ffp_pkg::COUNT_MAX
		: dvd_q[ffp_pkg::RATE_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tick_q <= ~action;
			t_q    <= t_clamp;
		end
		if (cmd.mul_init) begin
			p_q   <= ffp_pkg::PROD_W'(lr_eff) * ffp_pkg::PROD_W'(hr_eff);
			mhi_q <= '0;
			mlo_q <= t_q;
		end else if (cmd.mul_step) begin
			mhi_q <= mul_sum[ffp_pkg::PROD_W:1];
			mlo_q <= {mul_sum[0], mlo_q[ffp_pkg::CATCH_W-1:1]};
		end
		if (cmd.accum) begin
			dvd_q <= sum[ffp_pkg::SUM_W-1:ffp_pkg::FRAC_W];
			low_q <= sum[ffp_pkg::FRAC_W-1:0];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[ffp_pkg::DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[ffp_pkg::RATE_W-1:0] : trial[ffp_pkg::RATE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.commit) begin
			acc_q <= {rem_q, low_q};
		end
	end

endmodule

// ----- design/fractional_frame_pacer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_frame_pacer
// Phase accumulator that turns host ticks or elapsed time into frame counts.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A host tick skips the multiply; an
// elapsed-time item first has a shift-add multiply of the rate product by
// the clamped time. Both run a restoring divide by the host threshold, one
// quotient bit per cycle. The result sits in an output register, so a new
// item is taken while it waits; the next result is held back only until
// that one is taken. Rate registers at zero select 12 Hz and 60 Hz. The user
// must write configuration only while idle; the block does not enforce it.
module fractional_frame_pacer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic signed [ffp_pkg::TIME_W-1:0] elapsed_time,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ffp_pkg::RATE_W-1:0]        frame_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ffp_pkg::IDX_W-1:0]         cfg_index,
	input  logic [ffp_pkg::CATCH_W-1:0]       cfg_data
);

	logic [ffp_pkg::RATE_W-1:0]  logical_q;
	logic [ffp_pkg::RATE_W-1:0]  host_q;
	logic [ffp_pkg::CATCH_W-1:0] catchup_q;
	logic [ffp_pkg::RATE_W-1:0]  lr_eff;
	logic [ffp_pkg::RATE_W-1:0]  hr_eff;
	logic [ffp_pkg::RATE_W-1:0]  count;
	logic [ffp_pkg::RATE_W-1:0]  frame_count_q;
	logic                        out_valid_q;
	logic                        tick;
	ffp_pkg::ffp_cmd_t           cmd;
	ffp_pkg::ffp_sts_t           sts;

	assign cfg_ready   = 1'b1;
	assign lr_eff      = (logical_q == '0) ? ffp_pkg::DEF_LOGICAL : logical_q;
	assign hr_eff      = (host_q == '0) ? ffp_pkg::DEF_HOST : host_q;
	assign out_valid   = out_valid_q;
	assign frame_count = frame_count_q;

	assign sts.tick     = tick;
	assign sts.out_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logical_q <= ffp_pkg::DEF_LOGICAL;
			host_q    <= ffp_pkg::DEF_HOST;
			catchup_q <= ffp_pkg::DEF_CATCHUP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ffp_pkg::REG_LOGICAL: logical_q <= cfg_data[ffp_pkg::RATE_W-1:0];
				ffp_pkg::REG_HOST:    host_q    <= cfg_data[ffp_pkg::RATE_W-1:0];
				ffp_pkg::REG_CATCHUP: catchup_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			frame_count_q <= count;
		end
	end

	ffp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (action),
		.elapsed_time (elapsed_time),
		.lr_eff       (lr_eff),
		.hr_eff       (hr_eff),
		.max_catchup  (catchup_q),
		.tick         (tick),
		.count        (count)
	);

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("result committed over an untaken result");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted transaction did not start work");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_stall))
		else $error("result appeared without work in progress");

endmodule

// ----- verif/ffp_pacing_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_pacing_checker
// Watches the item, result and configuration channels of the frame pacer. It
// keeps its own copy of the rate registers and the phase accumulator. For each
// accepted item it works out the frame count that is due and queues it. Each
// accepted result is compared with the oldest queued count. Mismatches and
// unexpected results are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module ffp_pacing_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              action,
	input  logic signed [ffp_pkg::TIME_W-1:0] elapsed_time,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [ffp_pkg::RATE_W-1:0]        frame_count,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [ffp_pkg::IDX_W-1:0]         cfg_index,
	input  logic [ffp_pkg::CATCH_W-1:0]       cfg_data,
	output int                                mismatch_count,
	output int                                frames_pending
);

	logic [ffp_pkg::RATE_W-1:0]  logical_q8;
	logic [ffp_pkg::RATE_W-1:0]  host_q8;
	logic [ffp_pkg::CATCH_W-1:0] catchup_limit;
	logic [63:0]                 phase_acc;
	logic [ffp_pkg::RATE_W-1:0]  due_frames[$];
	logic [ffp_pkg::RATE_W-1:0]  oldest_due;

	function automatic logic [ffp_pkg::RATE_W-1:0] next_frame_count(logic act,
		logic signed [ffp_pkg::TIME_W-1:0] et);
		logic [ffp_pkg::RATE_W-1:0]  lr;
		logic [ffp_pkg::RATE_W-1:0]  hr;
		logic [ffp_pkg::CATCH_W-1:0] t;
		logic [79:0]                 gain;
		logic [63:0]                 threshold;
		logic [63:0]                 frames;
		lr = (logical_q8 == '0) ? ffp_pkg::DEF_LOGICAL : logical_q8;
		hr = (host_q8 == '0) ? ffp_pkg::DEF_HOST : host_q8;
		if (!act) begin
			phase_acc = phase_acc + {24'd0, lr, 16'd0};
		end else begin
			if (et < 0) begin
				t = '0;
			end else if ($unsigned(et) > {7'd0, catchup_limit}) begin
				t = catchup_limit;
			end else begin
				t = et[ffp_pkg::CATCH_W-1:0];
			end
			gain = ({56'd0, lr} * {56'd0, hr} * {55'd0, t}) >> 12;
			phase_acc = phase_acc + gain[63:0];
		end
		threshold = {24'd0, hr, 16'd0};
		frames = phase_acc / threshold;
		phase_acc = phase_acc % threshold;
		return (frames > {40'd0, ffp_pkg::COUNT_MAX}) ? ffp_pkg::COUNT_MAX
			: frames[ffp_pkg::RATE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logical_q8 = ffp_pkg::DEF_LOGICAL;
			host_q8 = ffp_pkg::DEF_HOST;
			catchup_limit = ffp_pkg::DEF_CATCHUP;
			phase_acc = '0;
			due_frames.delete();
			mismatch_count = 0;
			frames_pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_frames.size() == 0) begin
					$error("frame_count: unexpected transaction, actual %0d", frame_count);
					mismatch_count++;
				end else begin
					oldest_due = due_frames.pop_front();
					if (frame_count !== oldest_due) begin
						$error("frame_count: expected %0d, actual %0d", oldest_due, frame_count);
						mismatch_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ffp_pkg::REG_LOGICAL: logical_q8 = cfg_data[ffp_pkg::RATE_W-1:0];
					ffp_pkg::REG_HOST:    host_q8 = cfg_data[ffp_pkg::RATE_W-1:0];
					ffp_pkg::REG_CATCHUP: catchup_limit = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				due_frames.push_back(next_frame_count(action, elapsed_time));
			frames_pending = due_frames.size();
		end
	end

endmodule

// ----- verif/tb_fractional_frame_pacer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fractional_frame_pacer
// Testbench for the fractional frame pacer. A short directed run hits tick
// items, clamped and negative elapsed times and the catch-up limit. It then
// runs phases of random items under changing rate and limit settings,
// extremes among them. Each phase uses one idle pattern on the item and
// result channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_fractional_frame_pacer;

	localparam logic [ffp_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PHASES = 12;
	localparam int PER_PHASE = 104;
	localparam int DRAIN_CYCLES = 100;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic                              action;
	logic signed [ffp_pkg::TIME_W-1:0] elapsed_time;
	logic                              out_valid;
	logic                              out_stall;
	logic [ffp_pkg::RATE_W-1:0]        frame_count;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [ffp_pkg::IDX_W-1:0]         cfg_index;
	logic [ffp_pkg::CATCH_W-1:0]       cfg_data;
	int                                mismatch_count;
	int                                frames_pending;
	int                                src_idle;
	int                                sink_stall;
	int                                sent_items;

	fractional_frame_pacer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.elapsed_time (elapsed_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_count  (frame_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	ffp_pacing_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.elapsed_time   (elapsed_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_count    (frame_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.frames_pending (frames_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < sink_stall);
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic push_item(logic act, logic signed [ffp_pkg::TIME_W-1:0] et);
		if ($urandom_range(0, 99) < src_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(0, 99) < src_idle)
				@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		elapsed_time <= et;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		sent_items++;
	endtask

	task automatic write_reg(logic [ffp_pkg::IDX_W-1:0] idx,
		logic [ffp_pkg::CATCH_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (frames_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [ffp_pkg::CATCH_W-1:0]       lr_set;
		logic [ffp_pkg::CATCH_W-1:0]       hr_set;
		logic [ffp_pkg::CATCH_W-1:0]       limit;
		logic signed [ffp_pkg::TIME_W-1:0] et;
		int                                sel;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = 1'b0;
		elapsed_time = '0;
		cfg_valid = 1'b0;
		cfg_index = ffp_pkg::REG_LOGICAL;
		cfg_data = '0;
		src_idle = 0;
		sink_stall = 0;
		sent_items = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: 12 Hz logical, 60 Hz host, half-second limit
		push_item(1'b0, 32'sd0);
		push_item(1'b0, -32'sd1);
		push_item(1'b0, 32'sd0);
		push_item(1'b1, 32'sd0);
		push_item(1'b1, -32'sd1);
		push_item(1'b1, 32'sh8000_0000);
		push_item(1'b1, 32'sh7FFF_FFFF);
		push_item(1'b1, 32'sd524288);
		push_item(1'b1, 32'sd524289);
		push_item(1'b1, 32'sd524287);
		push_item(1'b1, 32'sd1);
		push_item(1'b1, 32'sd87381);
		push_item(1'b0, 32'sh5555_AAAA);
		drain_results();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					lr_set = '0;
					hr_set = '0;
					limit = '0;
				end
				1: begin
					lr_set = 25'hFF_FFFF;
					hr_set = 25'd1;
					limit = 25'h1FF_FFFF;
				end
				2: begin
					lr_set = 25'd1;
					hr_set = 25'hFF_FFFF;
					limit = 25'h1FF_FFFF;
				end
				3: begin
					// bit 24 must be dropped from the rate registers
					lr_set = 25'h100_0C00;
					hr_set = 25'h100_3C00;
					limit = 25'd1;
				end
				default: begin
					lr_set = ($urandom_range(0, 4) == 0) ? '0 : ffp_pkg::CATCH_W'($urandom);
					hr_set = ($urandom_range(0, 4) == 0) ? '0 : ffp_pkg::CATCH_W'($urandom);
					limit = ($urandom_range(0, 1) == 0) ?
						ffp_pkg::CATCH_W'($urandom_range(0, 2097152)) :
						ffp_pkg::CATCH_W'($urandom);
				end
			endcase
			write_reg(ffp_pkg::REG_LOGICAL, lr_set);
			write_reg(ffp_pkg::REG_HOST, hr_set);
			write_reg(ffp_pkg::REG_CATCHUP, limit);
			write_reg(REG_UNUSED, ffp_pkg::CATCH_W'($urandom));
			cfg_valid <= 1'b0;

			case (phase % 4)
				0: begin
					src_idle = 0;
					sink_stall = 0;
				end
				1: begin
					src_idle = 68;
					sink_stall = 0;
				end
				2: begin
					src_idle = 0;
					sink_stall = 68;
				end
				default: begin
					src_idle = 17;
					sink_stall = 17;
				end
			endcase

			for (int k = 0; k < PER_PHASE; k++) begin
				sel = $urandom_range(0, 9);
				case (sel)
					4: et = {1'b1, 31'($urandom)};
					5: et = $urandom;
					6: et = $urandom_range(0, limit);
					7: et = $signed({7'd0, limit}) + $urandom_range(0, 4) - 2;
					8: et = $urandom_range(0, 4096);
					9: et = 32'sh7FFF_FFFF - $urandom_range(0, 3);
					default: et = $urandom;
				endcase
				push_item(sel >= 4, et);
			end
			drain_results();
		end

		$display("%0d transactions over %0d rate and catch-up settings, four idle patterns",
			sent_items, PHASES + 1);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
